[rtl/csvtok_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// csvtok_pkg
// Character codes, result kinds and the result entry type of the CSV tokenizer.
// -----------------------------------------------------------------------------
package csvtok_pkg;

   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   typedef enum logic [1:0] {
      KIND_DATA       = 2'd0,
      KIND_FIELD_END  = 2'd1,
      KIND_RECORD_END = 2'd2,
      KIND_STREAM_END = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } result_type;

   // result queue geometry
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

[rtl/csv_record_tokenizer_top.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// csv_record_tokenizer_top
// Streaming CSV tokenizer: raw bytes in, field bytes and delimiters out.
// -----------------------------------------------------------------------------
// Takes one CSV byte per cycle while the result queue has room (req_tlast
// high marks end of stream, byte then ignored) and emits data bytes, field
// ends, record ends and a stream end on the rsp channel, with rsp_tlast on the
// final result of each input byte. The parser flags update in the cycle a
// byte is taken and its results go into a four-entry result queue; a byte is
// taken whenever the queue has room for two results, so with rsp_tready held
// high the block takes one byte per cycle and stalls only when end-of-stream
// transfers, which give two results, have built the queue up to three
// entries. Quoted fields, doubled quotes, and CR, LF or CRLF record ends are
// handled; an open record is closed at end of stream and all parser state
// returns to its reset values after it.
// -----------------------------------------------------------------------------
module csv_record_tokenizer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast    // last
);
   import csvtok_pkg::*;

   logic in_quotes_ff, in_quotes_in;
   logic quote_pending_ff, quote_pending_in;
   logic skip_lf_ff, skip_lf_in;
   logic field_empty_ff, field_empty_in;
   logic record_started_ff, record_started_in;

   result_type             queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wptr_ff, wptr_in;
   logic [QUEUE_AW-1:0]    rptr_ff, rptr_in;
   logic [QUEUE_AW:0]      count_ff, count_in;

   logic       accept;
   logic       pop;
   logic [1:0] nres;
   result_type res0;
   result_type res1;

   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;

   // room for two results regardless of the output side
   assign req_tready = (count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));

   // parser step
   always_comb begin
      logic handled;
      logic [7:0] c;
      c                 = req_tdata;
      handled           = 1'b0;
      in_quotes_in      = in_quotes_ff;
      quote_pending_in  = quote_pending_ff;
      skip_lf_in        = skip_lf_ff;
      field_empty_in    = field_empty_ff;
      record_started_in = record_started_ff;
      nres              = 2'd0;
      res0              = '{kind: KIND_DATA, data: 8'h00, last: 1'b1};
      res1              = '{kind: KIND_STREAM_END, data: 8'h00, last: 1'b1};

      if (req_tlast) begin
         if (record_started_ff) begin
            res0.kind = KIND_RECORD_END;
            res0.last = 1'b0;
            nres      = 2'd2;
         end else begin
            res0.kind = KIND_STREAM_END;
            nres      = 2'd1;
         end
         in_quotes_in      = 1'b0;
         quote_pending_in  = 1'b0;
         skip_lf_in        = 1'b0;
         field_empty_in    = 1'b1;
         record_started_in = 1'b0;
      end else begin
         skip_lf_in = 1'b0;
         if (skip_lf_ff && c == CH_LF) begin
            handled = 1'b1;   // drop the LF of a CRLF
         end
         if (!handled) begin
            record_started_in = 1'b1;
            if (quote_pending_ff) begin
               quote_pending_in = 1'b0;
               if (c == CH_QUOTE) begin
                  res0.data      = CH_QUOTE;
                  nres           = 2'd1;
                  field_empty_in = 1'b0;
                  handled        = 1'b1;
               end else begin
                  in_quotes_in = 1'b0;
               end
            end else if (in_quotes_ff) begin
               if (c == CH_QUOTE) begin
                  quote_pending_in = 1'b1;
               end else begin
                  res0.data      = c;
                  nres           = 2'd1;
                  field_empty_in = 1'b0;
               end
               handled = 1'b1;
            end
         end
         if (!handled) begin
            if (c == CH_COMMA) begin
               res0.kind      = KIND_FIELD_END;
               nres           = 2'd1;
               field_empty_in = 1'b1;
            end else if (c == CH_CR || c == CH_LF) begin
               res0.kind         = KIND_RECORD_END;
               nres              = 2'd1;
               field_empty_in    = 1'b1;
               record_started_in = 1'b0;
               skip_lf_in        = (c == CH_CR);
            end else if (c == CH_QUOTE && field_empty_ff) begin
               in_quotes_in = 1'b1;
            end else begin
               res0.data      = c;
               nres           = 2'd1;
               field_empty_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (accept) begin
         wptr_in  = wptr_ff + QUEUE_AW'(nres);
         count_in = count_in + (QUEUE_AW+1)'(nres);
      end
      if (pop) begin
         rptr_in  = rptr_ff + 1'b1;
         count_in = count_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff      <= 1'b0;
         quote_pending_ff  <= 1'b0;
         skip_lf_ff        <= 1'b0;
         field_empty_ff    <= 1'b1;
         record_started_ff <= 1'b0;
         wptr_ff           <= '0;
         rptr_ff           <= '0;
         count_ff          <= '0;
      end else begin
         if (accept) begin
            in_quotes_ff      <= in_quotes_in;
            quote_pending_ff  <= quote_pending_in;
            skip_lf_ff        <= skip_lf_in;
            field_empty_ff    <= field_empty_in;
            record_started_ff <= record_started_in;
         end
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && nres != 2'd0) begin
         queue_ff[wptr_ff] <= res0;
      end
      if (accept && nres == 2'd2) begin
         queue_ff[wptr_ff + 1'b1] <= res1;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = queue_ff[rptr_ff].data;
   assign rsp_tuser  = queue_ff[rptr_ff].kind;
   assign rsp_tlast  = queue_ff[rptr_ff].last;

   // never overrun the result queue
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("result queue overrun");

   // end of stream leaves the parser in its reset state with a result queued
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (!in_quotes_ff && !quote_pending_ff && !skip_lf_ff
                                 && field_empty_ff && !record_started_ff && rsp_tvalid))
      else $error("parser state not cleared after end of stream");

   // only data results carry a byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != KIND_DATA) |-> (rsp_tdata == 8'h00))
      else $error("non-data result carries a byte");

   // a record end that is not final must be followed by a stream end
   assert property (@(posedge clock) disable iff (reset)
      (pop && rsp_tuser == KIND_RECORD_END && !rsp_tlast)
         |=> (rsp_tvalid && rsp_tuser == KIND_STREAM_END))
      else $error("stream end missing after closing record end");

endmodule
